// ===== src/twad_pkg.sv =====
// Package for the tripwire and area event detector.
// Holds request codes, payload structs, the state enum and the control structs.
package twad_pkg;

  localparam int unsigned CoordW    = 14;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned TagW      = 8;
  localparam logic [CoordW-1:0] LineReset = 14'd2000;

  typedef enum logic [1:0] {
    REQ_MOVE  = 2'd0,
    REQ_SCAN  = 2'd1,
    REQ_TRIP  = 2'd2,
    REQ_AREA  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_READ,
    ST_TRIP,
    ST_AREA,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KeyW-1:0]   object_key;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [6:0]        object_index;
    logic [2:0]        rule_index;
    logic              rule_enable;
    logic [TagW-1:0]   rule_tag;
    logic [CoordW-1:0] corner_x0;
    logic [CoordW-1:0] corner_y0;
    logic [CoordW-1:0] corner_x1;
    logic [CoordW-1:0] corner_y1;
  } in_item_t;

  typedef struct packed {
    logic              event_kind;
    logic [TagW-1:0]   event_rule;
    logic              heading;
    logic [KeyW-1:0]   event_object;
    logic              last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture accepted input item
    logic do_match;    // resolve key match, update or allocate object
    logic read_obj;    // read the scanned slot
    logic step_trip;   // test tripwire rule at rule counter
    logic step_area;   // test area rule at rule counter
    logic rule_clr;    // reset rule counter
    logic pop_out;     // output transfer done
    logic write_rule;  // store rule write
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req;
    logic       slot_ok;    // scanned slot is occupied
    logic       rule_last;  // rule counter at final rule
    logic       hit;        // current rule fires
    logic       pend;       // an event is held for output
  } dp_stat_t;

endpackage

// ===== src/tripwire_area_event_detector_unit.sv =====
// Top level of the tripwire and area event detector.
// Depends on twad_pkg, twad_ctrl and twad_dp.
//
// One item is handled at a time. An update's position write lands in the
// cycle after its match. A scan walks the tripwire rules and then the area
// rules through one comparator unit, one rule per cycle while the output
// buffer has room; the walk waits while a new event finds the buffer full.
// Results leave through a one-entry output register and the final event of
// a scan carries last. The object key match is a parallel compare.
module tripwire_area_event_detector_unit import twad_pkg::*; #(
  parameter int unsigned OBJECTS = 128,
  parameter int unsigned RULES   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_st;

  twad_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd
  );

  // The controller sits in its drain state once in_stall holds and no
  // rule step or match is active; the datapath flushes the held event there.
  assign out_st = in_stall && !cmd.step_trip && !cmd.step_area &&
                  !cmd.do_match && !cmd.read_obj && !cmd.write_rule &&
                  !cmd.rule_clr;

  twad_dp #(.OBJECTS(OBJECTS), .RULES(RULES)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .out_valid, .out_data,
    .in_ctrl_out_st(out_st)
  );

endmodule

// ===== src/twad_ctrl.sv =====
// Controller for the tripwire and area event detector.
// Depends on twad_pkg for state, command and status types.
module twad_ctrl import twad_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_go;

  assign out_go = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        unique case (req_t'(stat.req))
          REQ_SCAN: state_nxt = ST_READ;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_READ: state_nxt = stat.slot_ok ? ST_TRIP : ST_OUT;
      ST_TRIP: begin
        if (stat.rule_last) state_nxt = ST_AREA;
      end
      ST_AREA: begin
        if (stat.rule_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Drains the final held event, which carries the last flag.
        if (!stat.pend || out_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = (state_r != ST_IDLE);
    cmd.load_item = (state_r == ST_IDLE) && in_valid;
    cmd.pop_out   = out_go;
    unique case (state_r)
      ST_MATCH: begin
        cmd.do_match   = (req_t'(stat.req) == REQ_MOVE);
        cmd.write_rule = (req_t'(stat.req) == REQ_TRIP) ||
                         (req_t'(stat.req) == REQ_AREA);
        cmd.read_obj   = (req_t'(stat.req) == REQ_SCAN);
        cmd.rule_clr   = 1'b1;
      end
      ST_READ: cmd.rule_clr = 1'b1;
      ST_TRIP: begin
        cmd.step_trip = 1'b1;
        cmd.rule_clr  = stat.rule_last;
      end
      ST_AREA: cmd.step_area = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/twad_dp.sv =====
// Datapath for the tripwire and area event detector: object table, rules,
// rule tests and the one-event output buffer. Depends on twad_pkg.
module twad_dp import twad_pkg::*; #(
  parameter int unsigned OBJECTS = 128,
  parameter int unsigned RULES   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      in_ctrl_out_st
);

  localparam int unsigned OW = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
  localparam int unsigned CW = $clog2(OBJECTS + 1);
  localparam int unsigned RW = (RULES > 1) ? $clog2(RULES) : 1;

  in_item_t item_r;

  // Key table in flops for the parallel match; positions in memories.
  logic [KeyW-1:0]   key_r [OBJECTS];
  logic [CoordW-1:0] py_mem [OBJECTS];
  logic [CoordW-1:0] nx_mem [OBJECTS];
  logic [CoordW-1:0] ny_mem [OBJECTS];
  logic [CW-1:0]     count_r;

  logic [RULES-1:0]  trip_en_r;
  logic [CoordW-1:0] trip_y_r [RULES];
  logic [TagW-1:0]   trip_tag_r [RULES];
  logic [RULES-1:0]  area_en_r;
  logic [CoordW-1:0] ax0_r [RULES];
  logic [CoordW-1:0] ay0_r [RULES];
  logic [CoordW-1:0] ax1_r [RULES];
  logic [CoordW-1:0] ay1_r [RULES];
  logic [TagW-1:0]   area_tag_r [RULES];

  logic [CoordW-1:0] sp_y_r, sn_x_r, sn_y_r;
  logic [KeyW-1:0]   skey_r;
  logic [RW-1:0]     rc_r;

  // Position writes land in the cycle after the match, once the old y is read.
  logic              upd_v_r;
  logic              upd_hit_r;
  logic [OW-1:0]     upd_idx_r;
  logic [CoordW-1:0] upd_ny_r;

  out_item_t hold_r;
  logic      hold_v_r;
  out_item_t obuf_r;
  out_item_t obuf_nxt;
  logic      obuf_v_r;

  // Parallel key match, first match wins.
  logic          found;
  logic [OW-1:0] found_idx;
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = OBJECTS - 1; i >= 0; i--) begin
      if ((CW'(i) < count_r) && key_r[i] == item_r.object_key) begin
        found     = 1'b1;
        found_idx = OW'(i);
      end
    end
  end

  logic          alloc;
  logic [OW-1:0] wr_idx;
  assign alloc  = !found && (count_r < CW'(OBJECTS));
  assign wr_idx = found ? found_idx : count_r[OW-1:0];

  logic [OW-1:0] scan_idx;
  logic          scan_ok;
  assign scan_idx = OW'(item_r.object_index);
  assign scan_ok  = (32'(item_r.object_index) < 32'(count_r)) &&
                    (32'(item_r.object_index) < OBJECTS);

  // Rule test at the rule counter.
  logic [CoordW-1:0] ly;
  logic trip_hit, area_hit, head;
  assign ly = trip_y_r[rc_r];
  assign trip_hit = trip_en_r[rc_r] &&
    ((sp_y_r < ly && sn_y_r >= ly) || (sp_y_r > ly && sn_y_r <= ly));
  assign area_hit = area_en_r[rc_r] &&
    sn_x_r >= ax0_r[rc_r] && sn_x_r <= ax1_r[rc_r] &&
    sn_y_r >= ay0_r[rc_r] && sn_y_r <= ay1_r[rc_r];
  assign head = (sn_y_r > sp_y_r) ? 1'b0 : 1'b1;

  logic      new_ev;
  out_item_t new_item;
  always_comb begin
    new_ev   = (cmd.step_trip && trip_hit) || (cmd.step_area && area_hit);
    new_item = '0;
    new_item.event_kind   = cmd.step_area;
    new_item.event_rule   = cmd.step_area ? area_tag_r[rc_r] : trip_tag_r[rc_r];
    new_item.heading      = cmd.step_trip ? head : 1'b0;
    new_item.event_object = skey_r;
  end

  // A held event moves to the output buffer when a later event arrives
  // or, marked last, when the scan ends. The rule walk waits on a full buffer.
  logic obuf_free, flush, advance;
  assign obuf_free = !obuf_v_r || cmd.pop_out;
  assign flush     = in_ctrl_out_st && hold_v_r && obuf_free;
  assign advance   = !(new_ev && hold_v_r && !obuf_free);

  always_comb begin
    obuf_nxt      = hold_r;
    obuf_nxt.last = flush;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.do_match && (found || alloc)) begin
      key_r[wr_idx] <= item_r.object_key;
      upd_idx_r     <= wr_idx;
      upd_hit_r     <= found;
      upd_ny_r      <= ny_mem[wr_idx];
    end
    if (upd_v_r) begin
      py_mem[upd_idx_r] <= upd_hit_r ? upd_ny_r : item_r.pos_y;
      nx_mem[upd_idx_r] <= item_r.pos_x;
      ny_mem[upd_idx_r] <= item_r.pos_y;
    end
    if (cmd.read_obj) begin
      sp_y_r <= py_mem[scan_idx];
      sn_x_r <= nx_mem[scan_idx];
      sn_y_r <= ny_mem[scan_idx];
      skey_r <= key_r[scan_idx];
    end
    if (new_ev && advance) hold_r <= new_item;
    if ((new_ev && hold_v_r && obuf_free) || flush) obuf_r <= obuf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      upd_v_r   <= 1'b0;
      rc_r      <= '0;
      hold_v_r  <= 1'b0;
      obuf_v_r  <= 1'b0;
      trip_en_r <= '1;
      area_en_r <= '0;
      for (int r = 0; r < RULES; r++) begin
        trip_y_r[r]   <= LineReset;
        trip_tag_r[r] <= TagW'(r);
        ax0_r[r] <= '0; ay0_r[r] <= '0; ax1_r[r] <= '0; ay1_r[r] <= '0;
        area_tag_r[r] <= '0;
      end
    end else begin
      if (cmd.do_match && alloc) count_r <= count_r + CW'(1);
      upd_v_r <= cmd.do_match && (found || alloc);
      if (cmd.rule_clr && !(cmd.step_trip && !advance)) rc_r <= '0;
      else if ((cmd.step_trip || cmd.step_area) && advance)
        rc_r <= (rc_r == RW'(RULES - 1)) ? '0 : rc_r + RW'(1);
      if (new_ev && advance)              hold_v_r <= 1'b1;
      else if (flush)                     hold_v_r <= 1'b0;
      if ((new_ev && hold_v_r && obuf_free) || flush) obuf_v_r <= 1'b1;
      else if (cmd.pop_out)                           obuf_v_r <= 1'b0;
      if (cmd.write_rule && 4'(item_r.rule_index) < 4'(RULES)) begin
        if (req_t'(item_r.req_type) == REQ_TRIP) begin
          trip_en_r[item_r.rule_index[RW-1:0]]  <= item_r.rule_enable;
          trip_tag_r[item_r.rule_index[RW-1:0]] <= item_r.rule_tag;
          trip_y_r[item_r.rule_index[RW-1:0]]   <= item_r.corner_y0;
        end else begin
          area_en_r[item_r.rule_index[RW-1:0]]  <= item_r.rule_enable;
          area_tag_r[item_r.rule_index[RW-1:0]] <= item_r.rule_tag;
          ax0_r[item_r.rule_index[RW-1:0]] <= item_r.corner_x0;
          ay0_r[item_r.rule_index[RW-1:0]] <= item_r.corner_y0;
          ax1_r[item_r.rule_index[RW-1:0]] <= item_r.corner_x1;
          ay1_r[item_r.rule_index[RW-1:0]] <= item_r.corner_y1;
        end
      end
    end
  end

  always_comb begin
    stat.req       = item_r.req_type;
    stat.slot_ok   = scan_ok;
    stat.rule_last = (rc_r == RW'(RULES - 1)) && advance;
    stat.hit       = new_ev;
    // Pending while anything is still held or buffered.
    stat.pend      = hold_v_r || obuf_v_r;
  end

  assign out_valid = obuf_v_r;
  assign out_data  = obuf_r;

endmodule
